@@ rtl/lsfs_pkg.sv @@
`default_nettype none
package lsfs_pkg;

  // Size of the strip that the stores are built for
  localparam int unsigned MaxLeds = 64;

  // Frame framing bytes
  localparam logic [7:0]  StartByte  = 8'h00;
  localparam logic [7:0]  StopByte   = 8'hFF;
  localparam logic [7:0]  BrightMark = 8'hE0;
  localparam int unsigned EdgeBytes  = 4;

  // Command codes on func
  localparam logic [3:0] FUNC_TICK       = 4'd0;
  localparam logic [3:0] FUNC_SET_RGB    = 4'd1;
  localparam logic [3:0] FUNC_SET_RGBB   = 4'd2;
  localparam logic [3:0] FUNC_SET_BRIGHT = 4'd3;
  localparam logic [3:0] FUNC_ALL_RGB    = 4'd4;
  localparam logic [3:0] FUNC_ALL_RGBB   = 4'd5;
  localparam logic [3:0] FUNC_ALL_BRIGHT = 4'd6;
  localparam logic [3:0] FUNC_REMAP      = 4'd7;
  localparam logic [3:0] FUNC_SWAP       = 4'd8;

  // Operation carried by a token walking the cell row
  typedef enum logic [2:0] {
    OP_SET,
    OP_ALL,
    OP_REMAP,
    OP_SWAP,
    OP_LOOKUP,
    OP_READ
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  // Token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic       vld;
    op_e        op;
    logic [7:0] a;          // target cell index
    logic [7:0] c;          // second index, map value, or lookup result
    logic [7:0] len;        // used strip length
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
    logic       wr_rgb;
    logic       wr_bright;
  } token_t;

endpackage
`default_nettype wire

@@ rtl/lsfs_cell.sv @@
`default_nettype none
module lsfs_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned IdxW = 6
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  lsfs_pkg::token_t tok_i,
  output lsfs_pkg::token_t tok_o
);

  logic [7:0]      red_q, green_q, blue_q, bright_q;
  logic [7:0]      red_d, green_d, blue_d, bright_d;
  logic [IdxW-1:0] map_q, map_d;
  lsfs_pkg::token_t tok_q, tok_d;

  logic hit_a, hit_c, in_strip, wr_store;

  // Apply the passing token to this LED's entry
  always_comb begin
    tok_d    = tok_i;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    bright_d = bright_q;
    map_d    = map_q;
    hit_a    = tok_i.vld && (tok_i.a == 8'(Idx));
    hit_c    = tok_i.vld && (tok_i.c == 8'(Idx));
    in_strip = 8'(Idx) < tok_i.len;
    wr_store = 1'b0;
    case (tok_i.op)
      lsfs_pkg::OP_SET: begin
        wr_store = hit_a;
      end
      lsfs_pkg::OP_ALL: begin
        wr_store = tok_i.vld && in_strip;
      end
      lsfs_pkg::OP_REMAP: begin
        if (hit_a) map_d = IdxW'(tok_i.c);
      end
      lsfs_pkg::OP_SWAP: begin
        // second write wins, as map[c]=a is applied last
        if (hit_a) map_d = IdxW'(tok_i.c);
        if (hit_c) map_d = IdxW'(tok_i.a);
      end
      lsfs_pkg::OP_LOOKUP: begin
        if (hit_a) tok_d.c = 8'(map_q);
      end
      lsfs_pkg::OP_READ: begin
        if (hit_a) begin
          tok_d.red    = red_q;
          tok_d.green  = green_q;
          tok_d.blue   = blue_q;
          tok_d.bright = bright_q;
        end
      end
      default: begin
      end
    endcase
    if (wr_store && tok_i.wr_rgb) begin
      red_d   = tok_i.red;
      green_d = tok_i.green;
      blue_d  = tok_i.blue;
    end
    if (wr_store && tok_i.wr_bright) bright_d = tok_i.bright;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      bright_q <= '0;
      map_q    <= IdxW'(Idx);
      tok_q    <= '0;
    end else begin
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      bright_q <= bright_d;
      map_q    <= map_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

@@ rtl/lsfs_chain.sv @@
`default_nettype none
module lsfs_chain #(
  parameter int unsigned MaxLeds = lsfs_pkg::MaxLeds,
  parameter int unsigned IdxW    = 6
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  lsfs_pkg::token_t tok_i,
  output lsfs_pkg::token_t tok_o
);

  lsfs_pkg::token_t link [MaxLeds+1];

  assign link[0] = tok_i;

  // One cell per LED, token advances one cell per cycle
  for (genvar i = 0; i < MaxLeds; i++) begin : g_cell
    lsfs_cell #(
      .Idx  (i),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (link[i]),
      .tok_o  (link[i+1])
    );
  end

  assign tok_o = link[MaxLeds];

endmodule
`default_nettype wire

@@ rtl/led_strip_frame_streamer_top.sv @@
`default_nettype none
// LED strip frame streamer. Each LED's color, brightness and map entry live in
// one cell of a row of MAX_LEDS cells; a command travels down the row as a
// token, one cell per clock. Start and stop bytes of a tick finish without
// busy, the byte appearing in the cycle after the start; a tick with no frame
// to send finishes without busy and returns nothing. A tick that sends an LED
// byte, set-all, remap and swap hold busy while the token walks the row and
// return their item on the cycle busy drops; set-one walks the row twice (map
// lookup, then write). Range errors and unknown commands return in the cycle
// after. Results appear on strobe_o for one cycle each and cannot be held off.
module led_strip_frame_streamer_top #(
  parameter int unsigned MAX_LEDS = lsfs_pkg::MaxLeds
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  output logic       busy_o,
  input  wire [3:0]  func_i,
  input  wire [7:0]  led_index_i,
  input  wire [7:0]  other_index_i,
  input  wire [7:0]  red_i,
  input  wire [7:0]  green_i,
  input  wire [7:0]  blue_i,
  input  wire [7:0]  bright_i,
  input  wire        strip_length_we_i,
  input  wire [6:0]  strip_length_i,
  output logic       strobe_o,
  output logic       is_byte_o,
  output logic [7:0] spi_byte_o,
  output logic       error_o,
  output logic       frame_end_o
);

  localparam int unsigned IdxW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned PW   = $clog2(2 * lsfs_pkg::EdgeBytes + 4 * MAX_LEDS);

  lsfs_pkg::state_e state_q, state_d;
  lsfs_pkg::token_t tok_l, tok_r;

  logic [7:0]    len_q;
  logic [7:0]    len_used;
  logic          pend_q, pend_d, send_q, send_d;
  logic [PW-1:0] pos_q, pos_d, pos_cur, led_off;
  logic [PW:0]   pos_x, data_end, total;
  logic          is_last, is_led;
  logic [1:0]    part_q, part_d;
  logic          last_q, last_d;
  logic          accept;

  logic       strobe_d, is_byte_d, error_d, frame_end_d;
  logic [7:0] spi_byte_d;
  logic       strobe_q;

  // Row of LED cells
  lsfs_chain #(
    .MaxLeds (MAX_LEDS),
    .IdxW    (IdxW)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_l),
    .tok_o  (tok_r)
  );

  // Strip length clamped to 1..MAX_LEDS
  always_comb begin
    if (len_q == 8'd0) begin
      len_used = 8'd1;
    end else if (len_q > 8'(MAX_LEDS)) begin
      len_used = 8'(MAX_LEDS);
    end else begin
      len_used = len_q;
    end
  end

  // Frame byte layout at the current position
  always_comb begin
    pos_cur  = send_q ? pos_q : '0;
    pos_x    = {1'b0, pos_cur};
    data_end = (PW+1)'({len_used, 2'b00}) + (PW+1)'(lsfs_pkg::EdgeBytes);
    total    = data_end + (PW+1)'(lsfs_pkg::EdgeBytes);
    is_last  = (pos_x + (PW+1)'(1)) >= total;
    is_led   = (pos_x >= (PW+1)'(lsfs_pkg::EdgeBytes)) && (pos_x < data_end);
    led_off  = pos_cur - PW'(lsfs_pkg::EdgeBytes);
  end

  assign accept = start_i && (state_q == lsfs_pkg::ST_IDLE);
  assign busy_o = (state_q != lsfs_pkg::ST_IDLE);

  // Command sequencing
  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    send_d      = send_q;
    pos_d       = pos_q;
    part_d      = part_q;
    last_d      = last_q;
    tok_l       = '0;
    strobe_d    = 1'b0;
    is_byte_d   = 1'b0;
    spi_byte_d  = 8'd0;
    error_d     = 1'b0;
    frame_end_d = 1'b0;

    // common token payload from the command ports
    tok_l.a         = led_index_i;
    tok_l.c         = other_index_i;
    tok_l.len       = len_used;
    tok_l.red       = red_i;
    tok_l.green     = green_i;
    tok_l.blue      = blue_i;
    tok_l.bright    = bright_i;
    tok_l.wr_rgb    = (func_i != lsfs_pkg::FUNC_SET_BRIGHT) &&
                      (func_i != lsfs_pkg::FUNC_ALL_BRIGHT);
    tok_l.wr_bright = (func_i != lsfs_pkg::FUNC_SET_RGB) &&
                      (func_i != lsfs_pkg::FUNC_ALL_RGB);
    tok_l.op        = lsfs_pkg::OP_SET;

    case (state_q)
      lsfs_pkg::ST_IDLE: begin
        if (accept) begin
          case (func_i)
            lsfs_pkg::FUNC_TICK: begin
              if (send_q || pend_q) begin
                if (!send_q) pend_d = 1'b0;
                send_d = !is_last;
                pos_d  = is_last ? '0 : PW'(pos_x + (PW+1)'(1));
                if (is_led) begin
                  tok_l.vld = 1'b1;
                  tok_l.op  = lsfs_pkg::OP_READ;
                  tok_l.a   = 8'(led_off >> 2);
                  part_d    = pos_cur[1:0];
                  last_d    = is_last;
                  state_d   = lsfs_pkg::ST_WALK;
                end else begin
                  strobe_d    = 1'b1;
                  is_byte_d   = 1'b1;
                  spi_byte_d  = (pos_x < (PW+1)'(lsfs_pkg::EdgeBytes)) ?
                                lsfs_pkg::StartByte : lsfs_pkg::StopByte;
                  frame_end_d = is_last;
                end
              end
            end
            lsfs_pkg::FUNC_SET_RGB, lsfs_pkg::FUNC_SET_RGBB,
            lsfs_pkg::FUNC_SET_BRIGHT: begin
              if (led_index_i >= len_used) begin
                strobe_d = 1'b1;
                error_d  = 1'b1;
              end else begin
                // first walk fetches the physical position
                tok_l.vld = 1'b1;
                tok_l.op  = lsfs_pkg::OP_LOOKUP;
                pend_d    = 1'b1;
                state_d   = lsfs_pkg::ST_WALK;
              end
            end
            lsfs_pkg::FUNC_ALL_RGB, lsfs_pkg::FUNC_ALL_RGBB,
            lsfs_pkg::FUNC_ALL_BRIGHT: begin
              tok_l.vld = 1'b1;
              tok_l.op  = lsfs_pkg::OP_ALL;
              pend_d    = 1'b1;
              state_d   = lsfs_pkg::ST_WALK;
            end
            lsfs_pkg::FUNC_REMAP, lsfs_pkg::FUNC_SWAP: begin
              if ((led_index_i >= len_used) || (other_index_i >= len_used)) begin
                strobe_d = 1'b1;
                error_d  = 1'b1;
              end else begin
                tok_l.vld = 1'b1;
                tok_l.op  = (func_i == lsfs_pkg::FUNC_SWAP) ?
                            lsfs_pkg::OP_SWAP : lsfs_pkg::OP_REMAP;
                state_d   = lsfs_pkg::ST_WALK;
              end
            end
            default: begin
              strobe_d = 1'b1;
              error_d  = 1'b1;
            end
          endcase
        end
      end
      lsfs_pkg::ST_WALK: begin
        if (tok_r.vld) begin
          case (tok_r.op)
            lsfs_pkg::OP_LOOKUP: begin
              // second walk writes the looked-up cell
              tok_l     = tok_r;
              tok_l.op  = lsfs_pkg::OP_SET;
              tok_l.a   = (tok_r.c >= 8'(MAX_LEDS)) ? 8'(MAX_LEDS - 1) : tok_r.c;
            end
            lsfs_pkg::OP_READ: begin
              strobe_d    = 1'b1;
              is_byte_d   = 1'b1;
              frame_end_d = last_q;
              case (part_q)
                2'd0:    spi_byte_d = tok_r.bright | lsfs_pkg::BrightMark;
                2'd1:    spi_byte_d = tok_r.blue;
                2'd2:    spi_byte_d = tok_r.green;
                default: spi_byte_d = tok_r.red;
              endcase
              state_d = lsfs_pkg::ST_IDLE;
            end
            default: begin
              strobe_d = 1'b1;
              state_d  = lsfs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_d = lsfs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lsfs_pkg::ST_IDLE;
      pend_q   <= 1'b0;
      send_q   <= 1'b0;
      pos_q    <= '0;
      len_q    <= 8'(MAX_LEDS);
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      send_q   <= send_d;
      pos_q    <= pos_d;
      strobe_q <= strobe_d;
      if (strip_length_we_i) len_q <= {1'b0, strip_length_i};
    end
  end

  // Result payload and per-item context
  logic       is_byte_q, error_q, frame_end_q;
  logic [7:0] spi_byte_q;

  always_ff @(posedge clk_i) begin
    part_q      <= part_d;
    last_q      <= last_d;
    is_byte_q   <= is_byte_d;
    spi_byte_q  <= spi_byte_d;
    error_q     <= error_d;
    frame_end_q <= frame_end_d;
  end

  assign strobe_o    = strobe_q;
  assign is_byte_o   = is_byte_q;
  assign spi_byte_o  = spi_byte_q;
  assign error_o     = error_q;
  assign frame_end_o = frame_end_q;

endmodule
`default_nettype wire

@@ verif/lsfs_frame_checker.sv @@
`default_nettype none
// Watches the command and result channels of the LED strip frame streamer,
// keeps its own copy of the LED stores, position map and frame state, and
// compares every strobed result with the oldest expected one.
module lsfs_frame_checker
  import lsfs_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  wire        busy_i,
  input  wire [3:0]  func_i,
  input  wire [7:0]  led_index_i,
  input  wire [7:0]  other_index_i,
  input  wire [7:0]  red_i,
  input  wire [7:0]  green_i,
  input  wire [7:0]  blue_i,
  input  wire [7:0]  bright_i,
  input  wire        strip_length_we_i,
  input  wire [6:0]  strip_length_i,
  input  wire        strobe_i,
  input  wire        is_byte_i,
  input  wire [7:0]  spi_byte_i,
  input  wire        error_i,
  input  wire        frame_end_i,
  output int         mismatch_count_o,
  output int         outstanding_o
);

  typedef struct packed {
    logic       is_byte;
    logic [7:0] spi_byte;
    logic       error;
    logic       frame_end;
  } strip_result_t;

  // Shadow state of the block
  logic [7:0]  red_mem    [MaxLeds];
  logic [7:0]  green_mem  [MaxLeds];
  logic [7:0]  blue_mem   [MaxLeds];
  logic [7:0]  bright_mem [MaxLeds];
  logic [7:0]  led_map    [MaxLeds];
  logic        frame_queued;
  logic        frame_live;
  logic [8:0]  byte_pos;
  logic [6:0]  length_reg;

  strip_result_t expected_q [$];
  int            mismatches;

  // Zero and oversize lengths are clamped
  function automatic int unsigned active_leds(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > MaxLeds) return MaxLeds;
    return v;
  endfunction

  task automatic log_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_model();
    for (int i = 0; i < MaxLeds; i++) begin
      red_mem[i]    = 8'h00;
      green_mem[i]  = 8'h00;
      blue_mem[i]   = 8'h00;
      bright_mem[i] = 8'h00;
      led_map[i]    = 8'(i);
    end
    frame_queued = 1'b0;
    frame_live   = 1'b0;
    byte_pos     = '0;
    length_reg   = 7'(MaxLeds);
    expected_q.delete();
    mismatches   = 0;
  endtask

  // One tick: next byte of the frame in flight, or start the pending one
  task automatic frame_byte(output logic has_res, output strip_result_t res);
    int unsigned len;
    int unsigned data_end;
    int unsigned total;
    int unsigned pos;
    int unsigned led;
    int unsigned part;
    logic [7:0]  value;
    len      = active_leds(length_reg);
    data_end = EdgeBytes + 4 * len;
    total    = data_end + EdgeBytes;
    res      = '0;
    has_res  = 1'b0;
    if (!frame_live) begin
      if (!frame_queued) return;
      frame_queued = 1'b0;
      frame_live   = 1'b1;
      byte_pos     = '0;
    end
    pos = byte_pos;
    if (pos < EdgeBytes) begin
      value = StartByte;
    end else if (pos < data_end) begin
      led  = (pos - EdgeBytes) >> 2;
      part = (pos - EdgeBytes) & 3;
      if (led >= MaxLeds) led = MaxLeds - 1;
      case (part)
        0:       value = bright_mem[led] | BrightMark;
        1:       value = blue_mem[led];
        2:       value = green_mem[led];
        default: value = red_mem[led];
      endcase
    end else begin
      value = StopByte;
    end
    has_res       = 1'b1;
    res.is_byte   = 1'b1;
    res.spi_byte  = value;
    res.frame_end = (pos + 1 >= total);
    if (res.frame_end) begin
      frame_live = 1'b0;
      byte_pos   = '0;
    end else begin
      byte_pos = 9'(pos + 1);
    end
  endtask

  // Apply one accepted command to the shadow state
  task automatic run_command(input logic [3:0] f, input logic [7:0] a, input logic [7:0] c,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] br,
                             output logic has_res, output strip_result_t res);
    int unsigned len;
    int unsigned phys;
    len     = active_leds(length_reg);
    has_res = 1'b1;
    res     = '0;
    case (f)
      FUNC_TICK: frame_byte(has_res, res);
      FUNC_SET_RGB, FUNC_SET_RGBB, FUNC_SET_BRIGHT: begin
        if (a >= len) begin
          res.error = 1'b1;
        end else begin
          phys = led_map[a];
          if (phys >= MaxLeds) phys = MaxLeds - 1;
          if (f != FUNC_SET_BRIGHT) begin
            red_mem[phys]   = r;
            green_mem[phys] = g;
            blue_mem[phys]  = b;
          end
          if (f != FUNC_SET_RGB) bright_mem[phys] = br;
          frame_queued = 1'b1;
        end
      end
      FUNC_ALL_RGB, FUNC_ALL_RGBB, FUNC_ALL_BRIGHT: begin
        for (int i = 0; i < len; i++) begin
          if (f != FUNC_ALL_BRIGHT) begin
            red_mem[i]   = r;
            green_mem[i] = g;
            blue_mem[i]  = b;
          end
          if (f != FUNC_ALL_RGB) bright_mem[i] = br;
        end
        frame_queued = 1'b1;
      end
      FUNC_REMAP: begin
        if (a >= len || c >= len) res.error = 1'b1;
        else led_map[a] = c;
      end
      FUNC_SWAP: begin
        if (a >= len || c >= len) begin
          res.error = 1'b1;
        end else begin
          led_map[a] = c;
          led_map[c] = a;
        end
      end
      default: res.error = 1'b1;
    endcase
  endtask

  // Compare results, predict accepted items, track the length register
  always @(posedge clk_i or negedge rst_ni) begin
    strip_result_t got;
    strip_result_t want;
    logic          has_res;
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (strobe_i) begin
        got = '{is_byte_i, spi_byte_i, error_i, frame_end_i};
        if (expected_q.size() == 0) begin
          log_mismatch($sformatf("result with nothing expected: %p", got));
        end else begin
          want = expected_q.pop_front();
          if (got.is_byte !== want.is_byte)
            log_mismatch($sformatf("is_byte %b, want %b", got.is_byte, want.is_byte));
          if (got.spi_byte !== want.spi_byte)
            log_mismatch($sformatf("spi_byte %h, want %h", got.spi_byte, want.spi_byte));
          if (got.error !== want.error)
            log_mismatch($sformatf("error %b, want %b", got.error, want.error));
          if (got.frame_end !== want.frame_end)
            log_mismatch($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
        end
      end
      // an item taken at this edge still sees the old length
      if (start_i && !busy_i) begin
        run_command(func_i, led_index_i, other_index_i, red_i, green_i, blue_i, bright_i,
                    has_res, want);
        if (has_res) expected_q.push_back(want);
      end
      if (strip_length_we_i) length_reg = strip_length_i;
    end
    outstanding_o    <= expected_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule
`default_nettype wire

@@ verif/led_strip_frame_streamer_top_tb.sv @@
`default_nettype none
module led_strip_frame_streamer_top_tb;
  import lsfs_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 2 * MaxLeds + 8;
  localparam int ItemTarget    = 1000;
  localparam int PhaseItems    = 80;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] led_index;
    logic [7:0] other_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
  } led_cmd_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       start       = 1'b0;
  logic [3:0] func        = '0;
  logic [7:0] led_index   = '0;
  logic [7:0] other_index = '0;
  logic [7:0] red         = '0;
  logic [7:0] green       = '0;
  logic [7:0] blue        = '0;
  logic [7:0] bright      = '0;
  logic       len_we      = 1'b0;
  logic [6:0] len_value   = '0;
  logic       busy;
  logic       strobe;
  logic       is_byte;
  logic [7:0] spi_byte;
  logic       error;
  logic       frame_end;
  int         mismatch_count;
  int         outstanding;
  int         items_sent  = 0;
  int         idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  led_strip_frame_streamer_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_o            (busy),
    .func_i            (func),
    .led_index_i       (led_index),
    .other_index_i     (other_index),
    .red_i             (red),
    .green_i           (green),
    .blue_i            (blue),
    .bright_i          (bright),
    .strip_length_we_i (len_we),
    .strip_length_i    (len_value),
    .strobe_o          (strobe),
    .is_byte_o         (is_byte),
    .spi_byte_o        (spi_byte),
    .error_o           (error),
    .frame_end_o       (frame_end)
  );

  lsfs_frame_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_i            (busy),
    .func_i            (func),
    .led_index_i       (led_index),
    .other_index_i     (other_index),
    .red_i             (red),
    .green_i           (green),
    .blue_i            (blue),
    .bright_i          (bright),
    .strip_length_we_i (len_we),
    .strip_length_i    (len_value),
    .strobe_i          (strobe),
    .is_byte_i         (is_byte),
    .spi_byte_i        (spi_byte),
    .error_i           (error),
    .frame_end_i       (frame_end),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  // Watchdog: too long with neither an item nor a result moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Present one item and hold it until the block takes it
  task automatic drive_item(led_cmd_t cmd);
    start       <= 1'b1;
    func        <= cmd.func;
    led_index   <= cmd.led_index;
    other_index <= cmd.other_index;
    red         <= cmd.red;
    green       <= cmd.green;
    blue        <= cmd.blue;
    bright      <= cmd.bright;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Stop sending and wait for every expected result
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_length(logic [6:0] v);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    len_we    <= 1'b1;
    len_value <= v;
    @(posedge clk);
    len_we    <= 1'b0;
  endtask

  // Mostly well-formed commands for the current length, some noise
  function automatic led_cmd_t random_command(int unsigned len);
    led_cmd_t    cmd;
    int unsigned roll;
    cmd.func        = FUNC_TICK;
    cmd.led_index   = 8'($urandom);
    cmd.other_index = 8'($urandom);
    cmd.red         = 8'($urandom);
    cmd.green       = 8'($urandom);
    cmd.blue        = 8'($urandom);
    cmd.bright      = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      cmd.func = FUNC_TICK;
    end else if (roll < 70) begin
      cmd.func      = 4'($urandom_range(FUNC_SET_RGB, FUNC_SET_BRIGHT));
      cmd.led_index = 8'($urandom_range(0, len - 1));
    end else if (roll < 76) begin
      cmd.func = 4'($urandom_range(FUNC_ALL_RGB, FUNC_ALL_BRIGHT));
    end else if (roll < 84) begin
      cmd.func        = ($urandom_range(0, 1) != 0) ? FUNC_REMAP : FUNC_SWAP;
      cmd.led_index   = 8'($urandom_range(0, len - 1));
      cmd.other_index = 8'($urandom_range(0, len - 1));
    end else if (roll < 92) begin
      // indices left fully random
      cmd.func = 4'($urandom_range(FUNC_SET_RGB, FUNC_SWAP));
    end else if (roll < 96) begin
      // index one past the end of the strip
      cmd.func        = 4'($urandom_range(FUNC_SET_RGB, FUNC_SWAP));
      cmd.led_index   = ($urandom_range(0, 1) != 0) ? 8'(len) : 8'($urandom_range(0, len - 1));
      cmd.other_index = 8'(len);
      if (cmd.func < FUNC_REMAP) cmd.led_index = 8'(len);
    end else begin
      cmd.func = 4'($urandom_range(FUNC_SWAP + 1, 15));
    end
    return cmd;
  endfunction

  initial begin
    int unsigned roll;
    int unsigned len;
    int          burst_left;
    int          phase;
    logic [6:0]  length_v;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every command, errors, unknown codes
    drive_item('{FUNC_TICK,       8'd0,   8'd0,   8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{FUNC_SET_RGB,    8'd0,   8'd0,   8'hFF, 8'h00, 8'h55, 8'h00});
    drive_item('{FUNC_SET_RGBB,   8'd63,  8'd255, 8'h00, 8'hFF, 8'hAA, 8'hFF});
    drive_item('{FUNC_SET_BRIGHT, 8'd31,  8'd0,   8'hFF, 8'hFF, 8'hFF, 8'h00});
    drive_item('{FUNC_SET_RGB,    8'd64,  8'd0,   8'h11, 8'h22, 8'h33, 8'h44});
    drive_item('{FUNC_SET_RGBB,   8'd255, 8'd0,   8'h11, 8'h22, 8'h33, 8'h44});
    drive_item('{FUNC_SET_BRIGHT, 8'd128, 8'd0,   8'h11, 8'h22, 8'h33, 8'h44});
    drive_item('{FUNC_ALL_RGB,    8'd0,   8'd0,   8'h12, 8'h34, 8'h56, 8'h78});
    drive_item('{FUNC_ALL_RGBB,   8'd0,   8'd0,   8'h9A, 8'hBC, 8'hDE, 8'h1F});
    drive_item('{FUNC_ALL_BRIGHT, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00, 8'hE5});
    drive_item('{FUNC_REMAP,      8'd0,   8'd63,  8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{FUNC_REMAP,      8'd64,  8'd0,   8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{FUNC_REMAP,      8'd0,   8'd255, 8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{FUNC_SWAP,       8'd1,   8'd2,   8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{FUNC_SWAP,       8'd3,   8'd64,  8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{FUNC_SWAP,       8'd255, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{FUNC_SET_RGBB,   8'd0,   8'd0,   8'hC3, 8'h3C, 8'h5A, 8'hA5});
    drive_item('{4'd9,            8'd0,   8'd0,   8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{4'd15,           8'hFF,  8'hFF,  8'hFF, 8'hFF, 8'hFF, 8'hFF});

    // Shrink the strip: led 0 now maps beyond it, then stream part of a frame
    write_length(7'd2);
    drive_item('{FUNC_SET_RGB,    8'd0,   8'd0,   8'h01, 8'h02, 8'h04, 8'h08});
    repeat (6) drive_item('{FUNC_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00});
    drive_item('{FUNC_SET_BRIGHT, 8'd1,   8'd0,   8'h00, 8'h00, 8'h00, 8'h1E});
    // Zero length acts as one LED, frame already in flight
    write_length(7'd0);
    repeat (4) drive_item('{FUNC_TICK, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00});

    // Random phases, each with its own strip length
    phase = 0;
    while (items_sent < ItemTarget) begin
      roll = $urandom_range(0, 99);
      if (phase == 0)      length_v = 7'd127;
      else if (roll < 10)  length_v = 7'd0;
      else if (roll < 20)  length_v = 7'd1;
      else if (roll < 70)  length_v = 7'($urandom_range(2, 6));
      else if (roll < 82)  length_v = 7'($urandom_range(7, 16));
      else if (roll < 88)  length_v = 7'(MaxLeds);
      else if (roll < 93)  length_v = 7'd127;
      else                 length_v = 7'($urandom_range(MaxLeds + 1, 126));
      write_length(length_v);
      len = (length_v == 0) ? 1 : ((length_v > MaxLeds) ? MaxLeds : length_v);

      burst_left = $urandom_range(1, 24);
      for (int k = 0; k < PhaseItems; k++) begin
        drive_item(random_command(len));
        burst_left--;
        if (burst_left <= 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            drain_results();
          end else begin
            start <= 1'b0;
            if (roll < 70)      repeat ($urandom_range(1, 4)) @(posedge clk);
            else if (roll < 95) repeat ($urandom_range(5, 40)) @(posedge clk);
            else                repeat ($urandom_range(60, 200)) @(posedge clk);
          end
          burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
        end
      end
      phase++;
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
